// ----- hdl/rm_pkg.sv -----
// Shared constants and types for the running median block.
`default_nettype none
package rm_pkg;

  localparam int CAPACITY     = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int MED_W        = SAMPLE_WIDTH + 1;
  localparam int COUNT_OUT_W  = 7;
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int GROUP_SIZE   = 8;
  localparam int NGROUP       = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // broadcast to every cell for one insertion
  typedef struct packed {
    logic    ins;
    logic    clr;
    sample_t x;
  } cell_ctrl_t;

  // what a cell hands to its upper neighbor
  typedef struct packed {
    logic    valid;
    logic    gt;
    sample_t value;
  } link_t;

endpackage
`default_nettype wire

// ----- hdl/rm_in_if.sv -----
// Input channel: one sample request with a stream start flag.
`default_nettype none
interface rm_in_if import rm_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    first_of_stream;

  modport source (output valid, output sample, output first_of_stream, input ready);
  modport sink   (input valid, input sample, input first_of_stream, output ready);
endinterface
`default_nettype wire

// ----- hdl/rm_out_if.sv -----
// Result channel: doubled median, held count and overflow flag.
`default_nettype none
interface rm_out_if import rm_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [MED_W-1:0] median_doubled;
  logic [COUNT_OUT_W-1:0]  sample_count;
  logic                    overflow;

  modport source (output valid, output median_doubled, output sample_count,
                  output overflow, input ready);
  modport sink   (input valid, input median_doubled, input sample_count,
                  input overflow, output ready);
endinterface
`default_nettype wire

// ----- hdl/running_median.sv -----
// Running median top level: sorted cell chain, median select and result register.
// Usage:
//   in_chan  : one request per sample; first_of_stream empties the store
//              before that sample is inserted.
//   out_chan : one result per request: median_doubled (sum of the two middle
//              values, or twice the middle one), sample_count and overflow.
// A request is inserted into the chain of CAPACITY compare-and-shift cells at
// the edge it is accepted. The median is then picked in two registered steps
// (grouped select, then add into the result register). A new request is
// accepted only once the previous result has been loaded there.
// The result register holds one finished result; a new request is accepted
// while it waits, and the block holds the next result back until out_chan
// takes the old one, stalling the input side from then on.
// When the store is full, a sample without first_of_stream is dropped, the
// median repeats and overflow is set.
// Reset (rst_n low, synchronous) empties the store and drops any pending
// result; stored sample values are not cleared.
`default_nettype none
module running_median import rm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rm_in_if.sink     in_chan,
  rm_out_if.source  out_chan
);

  typedef enum logic [1:0] {ST_IDLE, ST_GATHER, ST_SUM} state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    ovf_r;
  logic                    out_valid_r;
  logic signed [MED_W-1:0] med_r;
  logic [COUNT_OUT_W-1:0]  cnt_out_r;
  logic                    ovf_out_r;

  logic                    accept, full;
  logic [CNT_W-1:0]        count_m1;
  logic [ADDR_W-1:0]       lo_idx, hi_idx;
  cell_ctrl_t              ctrl;
  link_t                   links [CAPACITY];
  sample_t                 lo_vals [CAPACITY];
  sample_t                 hi_vals [CAPACITY];
  logic signed [MED_W-1:0] median_sum;
  logic                    out_free;

  localparam link_t HEAD = '{valid: 1'b1, gt: 1'b0, value: '0};

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign full          = (count_r == CNT_W'(CAPACITY));

  assign ctrl = '{ins: accept && (in_chan.first_of_stream || !full),
                  clr: in_chan.first_of_stream,
                  x:   in_chan.sample};

  always_comb begin
    if (in_chan.first_of_stream) begin
      count_nxt = CNT_W'(1);
    end else if (!full) begin
      count_nxt = count_r + CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // middle positions of the held samples; count is never 0 when used
  assign count_m1 = count_r - CNT_W'(1);
  assign lo_idx   = ADDR_W'(count_m1 >> 1);
  assign hi_idx   = ADDR_W'(count_r >> 1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t prev;
    if (i == 0) begin : g_head
      assign prev = HEAD;
    end else begin : g_body
      assign prev = links[i-1];
    end
    rm_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .idx    (ADDR_W'(i)),
      .lo_idx (lo_idx),
      .hi_idx (hi_idx),
      .prev   (prev),
      .link_o (links[i]),
      .lo_val (lo_vals[i]),
      .hi_val (hi_vals[i])
    );
  end

  rm_median u_median (
    .clk            (clk),
    .lo_vals        (lo_vals),
    .hi_vals        (hi_vals),
    .median_doubled (median_sum)
  );

  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in ST_SUM a taken result is replaced by the new one below
      if (out_valid_r && out_chan.ready && state_r != ST_SUM) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            count_r <= count_nxt;
            ovf_r   <= !in_chan.first_of_stream && full;
            state_r <= ST_GATHER;
          end
        end
        ST_GATHER: begin
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          if (out_free) begin
            med_r       <= median_sum;
            cnt_out_r   <= COUNT_OUT_W'(count_r);
            ovf_out_r   <= ovf_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.median_doubled = med_r;
  assign out_chan.sample_count   = cnt_out_r;
  assign out_chan.overflow       = ovf_out_r;

endmodule
`default_nettype wire

// ----- hdl/rm_cell.sv -----
// One slot of the sorted chain: compare with the new sample and shift up.
`default_nettype none
module rm_cell import rm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [ADDR_W-1:0] idx,
  input  wire logic [ADDR_W-1:0] lo_idx,
  input  wire logic [ADDR_W-1:0] hi_idx,
  input  wire link_t             prev,
  output link_t                  link_o,
  output sample_t                lo_val,
  output sample_t                hi_val
);

  logic    valid_r, valid_nxt;
  sample_t val_r, val_nxt;
  logic    valid_eff, gt;

  assign valid_eff = valid_r & ~ctrl.clr;
  assign gt        = valid_eff && (val_r > ctrl.x);
  assign link_o    = '{valid: valid_eff, gt: gt, value: val_r};

  always_comb begin
    // lower neighbor larger than x: shift its value up
    if (prev.gt) begin
      val_nxt = prev.value;
    end else if (gt || !valid_eff) begin
      val_nxt = ctrl.x;
    end else begin
      val_nxt = val_r;
    end
    valid_nxt = valid_eff | prev.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.ins) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      val_r <= val_nxt;
    end
  end

  assign lo_val = (idx == lo_idx) ? val_r : '0;
  assign hi_val = (idx == hi_idx) ? val_r : '0;

endmodule
`default_nettype wire

// ----- hdl/rm_median.sv -----
// Registered grouped OR of the two selected middle values, then their sum.
`default_nettype none
module rm_median import rm_pkg::*; (
  input  wire logic                    clk,
  input  wire sample_t                 lo_vals [CAPACITY],
  input  wire sample_t                 hi_vals [CAPACITY],
  output logic signed [MED_W-1:0]      median_doubled
);

  sample_t grp_lo_r [NGROUP];
  sample_t grp_hi_r [NGROUP];
  sample_t grp_lo_nxt [NGROUP];
  sample_t grp_hi_nxt [NGROUP];
  sample_t lo_sel, hi_sel;

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_lo_nxt[g] = '0;
      grp_hi_nxt[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < CAPACITY) begin
          grp_lo_nxt[g] = grp_lo_nxt[g] | lo_vals[g * GROUP_SIZE + j];
          grp_hi_nxt[g] = grp_hi_nxt[g] | hi_vals[g * GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_lo_r[g] <= grp_lo_nxt[g];
      grp_hi_r[g] <= grp_hi_nxt[g];
    end
  end

  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int g = 0; g < NGROUP; g++) begin
      lo_sel = lo_sel | grp_lo_r[g];
      hi_sel = hi_sel | grp_hi_r[g];
    end
  end

  assign median_doubled = MED_W'(lo_sel) + MED_W'(hi_sel);

endmodule
`default_nettype wire
